@@ sv/ultrasonic_echo_rangefinder_assert.svh @@
// assertion macros for the echo rangefinder checker
`ifndef ULTRASONIC_ECHO_RANGEFINDER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGEFINDER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define UER_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define UER_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/uer_pkg.sv @@
// shared types, constants and the segment table of the echo rangefinder
package uer_pkg;

  localparam int ECHO_COUNT_BITS_DEF = 16;

  localparam int PERIOD_W = 24;
  localparam int TRIG_W   = 8;
  localparam int SCALE_W  = 16;
  localparam int MM_W     = 13;
  localparam int DIGIT_W  = 4;
  localparam int SEG_W    = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MM  = 3'd4;

  localparam logic [PERIOD_W-1:0] PERIOD_RST  = 24'd660000;
  localparam logic [TRIG_W-1:0]   TRIGGER_RST = 8'd18;
  localparam logic [SCALE_W-1:0]  SCALE_RST   = 16'd12089;
  localparam logic [MM_W-1:0]     MIN_MM_RST  = 13'd30;
  localparam logic [MM_W-1:0]     MAX_MM_RST  = 13'd4000;

  // reciprocal constants for the decimal split (exact for the ranges used)
  localparam logic [13:0] RECIP_1000 = 14'd8389;  // 2^23 / 1000, rounded up
  localparam logic [5:0]  RECIP_100  = 6'd41;     // 2^12 / 100, rounded up
  localparam logic [7:0]  RECIP_10   = 8'd205;    // 2^11 / 10, rounded up

  typedef struct packed {
    logic trig;
    logic done;
  } beat_t;

  // common cathode, gfedcba, a in bit 0
  function automatic logic [SEG_W-1:0] seg7(input logic [DIGIT_W-1:0] dg);
    logic [SEG_W-1:0] s;
    case (dg)
      4'd0:    s = 7'h3f;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5b;
      4'd3:    s = 7'h4f;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6d;
      4'd6:    s = 7'h7d;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7f;
      4'd9:    s = 7'h6f;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

@@ sv/uer_ctrl.sv @@
// ranging sequencer: wait, trigger pulse, echo wait and echo width count
module uer_ctrl #(
  parameter int EchoCountBits = uer_pkg::ECHO_COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          echo_i,
  output logic                          in_ready_o,
  input  logic [uer_pkg::PERIOD_W-1:0]  period_i,
  input  logic [uer_pkg::TRIG_W-1:0]    trig_len_i,
  output logic                          out_valid_o,
  output uer_pkg::beat_t                out_beat_o,
  output logic [EchoCountBits-1:0]      out_count_o,
  input  logic                          out_ready_i
);
  import uer_pkg::*;

  localparam logic [1:0] PH_WAIT  = 2'd0;
  localparam logic [1:0] PH_TRIG  = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;
  localparam logic [1:0] PH_COUNT = 2'd3;

  logic [1:0]               phase_q, phase_d;
  logic [PERIOD_W-1:0]      tick_q, tick_d, tick_inc;
  logic [EchoCountBits-1:0] echo_q, echo_d;
  logic                     valid_q;
  beat_t                    beat_q, beat_d;
  logic [EchoCountBits-1:0] count_q;
  logic                     accept;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign tick_inc   = tick_q + PERIOD_W'(1);

  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    echo_d      = echo_q;
    beat_d.trig = 1'b0;
    beat_d.done = 1'b0;
    unique case (phase_q)
      PH_WAIT: begin
        tick_d = tick_inc;
        if (tick_inc >= period_i) begin
          phase_d = PH_TRIG;
          tick_d  = '0;
        end
      end
      PH_TRIG: begin
        beat_d.trig = 1'b1;
        tick_d      = tick_inc;
        if (tick_inc >= PERIOD_W'(trig_len_i)) begin
          phase_d = PH_HIGH;
          tick_d  = '0;
        end
      end
      PH_HIGH: begin
        if (echo_i) begin
          echo_d  = EchoCountBits'(1);
          phase_d = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (echo_i) begin
          // saturate on a long echo
          if (echo_q != '1) begin
            echo_d = echo_q + EchoCountBits'(1);
          end
        end else begin
          beat_d.done = 1'b1;
          echo_d      = '0;
          tick_d      = '0;
          phase_d     = PH_WAIT;
        end
      end
      default: phase_d = PH_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      tick_q  <= '0;
      echo_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        tick_q  <= tick_d;
        echo_q  <= echo_d;
      end
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  // count before this beat's update is the one the distance is built from
  always_ff @(posedge clk_i) begin
    if (accept) begin
      beat_q  <= beat_d;
      count_q <= echo_q;
    end
  end

  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;
  assign out_count_o = count_q;

endmodule

@@ sv/uer_scale.sv @@
// echo count to millimetres: product stage, then window check stage
module uer_scale #(
  parameter int EchoCountBits = uer_pkg::ECHO_COUNT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  uer_pkg::beat_t               in_beat_i,
  input  logic [EchoCountBits-1:0]     in_count_i,
  output logic                         in_ready_o,
  input  logic [uer_pkg::SCALE_W-1:0]  scale_i,
  input  logic [uer_pkg::MM_W-1:0]     min_mm_i,
  input  logic [uer_pkg::MM_W-1:0]     max_mm_i,
  output logic                         out_valid_o,
  output uer_pkg::beat_t               out_beat_o,
  output logic [uer_pkg::MM_W-1:0]     out_mm_o,
  input  logic                         out_ready_i
);
  import uer_pkg::*;

  localparam int ProdW = EchoCountBits + SCALE_W;
  localparam int CmpW  = (EchoCountBits > MM_W) ? EchoCountBits : MM_W;

  logic [ProdW-1:0]         prod;
  logic                     mul_valid_q, win_valid_q;
  logic                     mul_ready, win_ready;
  beat_t                    mul_beat_q, win_beat_q;
  logic [EchoCountBits-1:0] mm_raw_q;
  logic [CmpW-1:0]          mm_ext;
  logic [MM_W-1:0]          mm_win, mm_q;

  assign win_ready  = !win_valid_q || out_ready_i;
  assign mul_ready  = !mul_valid_q || win_ready;
  assign in_ready_o = mul_ready;

  // Q0.16 scale, keep the integer part
  assign prod = ProdW'(in_count_i) * ProdW'(scale_i);

  assign mm_ext = CmpW'(mm_raw_q);
  always_comb begin
    if (mm_ext < CmpW'(min_mm_i) || mm_ext > CmpW'(max_mm_i)) begin
      mm_win = '0;
    end else begin
      mm_win = mm_ext[MM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      win_valid_q <= 1'b0;
    end else begin
      if (mul_ready) begin
        mul_valid_q <= in_valid_i;
      end
      if (win_ready) begin
        win_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && mul_ready) begin
      mul_beat_q <= in_beat_i;
      mm_raw_q   <= prod[ProdW-1:SCALE_W];
    end
    if (mul_valid_q && win_ready) begin
      win_beat_q <= mul_beat_q;
      mm_q       <= mm_win;
    end
  end

  assign out_valid_o = win_valid_q;
  assign out_beat_o  = win_beat_q;
  assign out_mm_o    = mm_q;

endmodule

@@ sv/uer_disp.sv @@
// decimal split, held distance and digits, segment codes, output register
module uer_disp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  uer_pkg::beat_t                 in_beat_i,
  input  logic [uer_pkg::MM_W-1:0]       in_mm_i,
  output logic                           in_ready_o,
  output logic                           out_valid_o,
  output uer_pkg::beat_t                 out_beat_o,
  output logic [uer_pkg::MM_W-1:0]       out_mm_o,
  output logic [3:0][uer_pkg::DIGIT_W-1:0] out_digit_o,
  output logic [3:0][uer_pkg::SEG_W-1:0]   out_seg_o,
  input  logic                           out_ready_i
);
  import uer_pkg::*;

  logic        spl_valid_q, out_valid_q;
  logic        spl_ready, out_ready;
  beat_t       spl_beat_q, out_beat_q;
  logic [26:0] q1000_prod;
  logic [3:0]  thou;
  logic [12:0] rem1000;
  logic [3:0]  thou_q;
  logic [9:0]  rem_q;
  logic [15:0] q100_prod;
  logic [3:0]  hund;
  logic [9:0]  rem100_w;
  logic [6:0]  rem100;
  logic [14:0] q10_prod;
  logic [3:0]  tens;
  logic [6:0]  ones_w;
  logic [MM_W-1:0] mm_spl_q, mm_q;
  logic [3:0][DIGIT_W-1:0] digit_q;

  assign out_ready  = !out_valid_q || out_ready_i;
  assign spl_ready  = !spl_valid_q || out_ready;
  assign in_ready_o = spl_ready;

  // thousands and the remainder below 1000
  assign q1000_prod = 27'(in_mm_i) * 27'(RECIP_1000);
  assign thou       = q1000_prod[26:23];
  assign rem1000    = in_mm_i - 13'(thou) * 13'd1000;

  // hundreds, tens and ones from the remainder
  assign q100_prod = 16'(rem_q) * 16'(RECIP_100);
  assign hund      = q100_prod[15:12];
  assign rem100_w  = rem_q - 10'(hund) * 10'd100;
  assign rem100    = rem100_w[6:0];
  assign q10_prod  = 15'(rem100) * 15'(RECIP_10);
  assign tens      = q10_prod[14:11];
  assign ones_w    = rem100 - 7'(tens) * 7'd10;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spl_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_beat_q  <= '0;
      mm_q        <= '0;
      digit_q     <= '0;
    end else begin
      if (spl_ready) begin
        spl_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= spl_valid_q;
      end
      if (spl_valid_q && out_ready) begin
        out_beat_q <= spl_beat_q;
        // the display keeps its value until a new measurement lands
        if (spl_beat_q.done) begin
          mm_q       <= mm_spl_q;
          digit_q[3] <= thou_q;
          digit_q[2] <= hund;
          digit_q[1] <= tens;
          digit_q[0] <= ones_w[3:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && spl_ready) begin
      spl_beat_q <= in_beat_i;
      mm_spl_q   <= in_mm_i;
      thou_q     <= thou;
      rem_q      <= rem1000[9:0];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      out_seg_o[k] = seg7(digit_q[k]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;
  assign out_mm_o    = mm_q;
  assign out_digit_o = digit_q;

endmodule

@@ sv/ultrasonic_echo_rangefinder.sv @@
// echo rangefinder top level: configuration registers and the beat pipeline
//
// Input stream: one beat per timer tick, s_axis_tdata[0] is the sampled echo
// level. Output stream: one beat per input beat, in order, carrying the
// trigger pin level, a done flag on the beat a new distance is latched, the
// held distance in millimetres, its four decimal digits and segment codes.
// Throughput is one beat per clock cycle while m_axis_tready is high; a beat
// taken into the sequencer register passes on through the product, window
// check, decimal split and output registers to the output. The sequencer's
// tick and echo counters advance once per accepted beat, so all timing is
// counted in beats. Each stage holds its beat while the next one is full, so
// when m_axis_tready is low the pipeline fills and s_axis_tready drops; no
// beat is lost. The configuration port writes register cfg_addr_i with
// cfg_wdata_i when cfg_we_i is high; unknown indexes are ignored. Write it
// only while no beat is in flight.
// Reset restores the default registers, starts the wait period and clears
// the held distance and digits to zero.
module ultrasonic_echo_rangefinder #(
  parameter int EchoCountBits = uer_pkg::ECHO_COUNT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [0] echo_level
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] trigger_out, [1] measure_done, [14:2] distance_mm,
  // [18:15] digit_thousands, [22:19] digit_hundreds, [26:23] digit_tens,
  // [30:27] digit_ones, [37:31] seg_thousands, [44:38] seg_hundreds,
  // [51:45] seg_tens, [58:52] seg_ones, [63:59] zero
  output logic [63:0]                      m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [uer_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [uer_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import uer_pkg::*;

  logic [PERIOD_W-1:0] period_q;
  logic [TRIG_W-1:0]   trig_len_q;
  logic [SCALE_W-1:0]  scale_q;
  logic [MM_W-1:0]     min_mm_q, max_mm_q;

  logic                     ctl_valid, ctl_ready;
  beat_t                    ctl_beat;
  logic [EchoCountBits-1:0] ctl_count;
  logic                     scl_valid, scl_ready;
  beat_t                    scl_beat;
  logic [MM_W-1:0]          scl_mm;
  beat_t                    out_beat;
  logic [MM_W-1:0]          out_mm;
  logic [3:0][DIGIT_W-1:0]  out_digit;
  logic [3:0][SEG_W-1:0]    out_seg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= PERIOD_RST;
      trig_len_q <= TRIGGER_RST;
      scale_q    <= SCALE_RST;
      min_mm_q   <= MIN_MM_RST;
      max_mm_q   <= MAX_MM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_PERIOD:  period_q   <= cfg_wdata_i[PERIOD_W-1:0];
        CFG_TRIGGER: trig_len_q <= cfg_wdata_i[TRIG_W-1:0];
        CFG_SCALE:   scale_q    <= cfg_wdata_i[SCALE_W-1:0];
        CFG_MIN_MM:  min_mm_q   <= cfg_wdata_i[MM_W-1:0];
        CFG_MAX_MM:  max_mm_q   <= cfg_wdata_i[MM_W-1:0];
        default: ;
      endcase
    end
  end

  uer_ctrl #(.EchoCountBits(EchoCountBits)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .echo_i      (s_axis_tdata[0]),
    .in_ready_o  (s_axis_tready),
    .period_i    (period_q),
    .trig_len_i  (trig_len_q),
    .out_valid_o (ctl_valid),
    .out_beat_o  (ctl_beat),
    .out_count_o (ctl_count),
    .out_ready_i (ctl_ready)
  );

  uer_scale #(.EchoCountBits(EchoCountBits)) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ctl_valid),
    .in_beat_i   (ctl_beat),
    .in_count_i  (ctl_count),
    .in_ready_o  (ctl_ready),
    .scale_i     (scale_q),
    .min_mm_i    (min_mm_q),
    .max_mm_i    (max_mm_q),
    .out_valid_o (scl_valid),
    .out_beat_o  (scl_beat),
    .out_mm_o    (scl_mm),
    .out_ready_i (scl_ready)
  );

  uer_disp u_disp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (scl_valid),
    .in_beat_i   (scl_beat),
    .in_mm_i     (scl_mm),
    .in_ready_o  (scl_ready),
    .out_valid_o (m_axis_tvalid),
    .out_beat_o  (out_beat),
    .out_mm_o    (out_mm),
    .out_digit_o (out_digit),
    .out_seg_o   (out_seg),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {5'b0, out_seg[0], out_seg[1], out_seg[2], out_seg[3],
                         out_digit[0], out_digit[1], out_digit[2], out_digit[3],
                         out_mm, out_beat.done, out_beat.trig};

endmodule

@@ sv/uer_checker.sv @@
// port-level checks of the echo rangefinder, bound to the top level
`include "ultrasonic_echo_rangefinder_assert.svh"

module uer_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // a stalled output beat holds
  `UER_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")

  // an empty output stage leaves the whole pipeline ready
  `UER_ASSERT_NOW(a_empty_ready, !m_axis_tvalid, s_axis_tready, "input stalled with empty output stage")

  // the trigger pulse and a finished measurement never share a tick
  `UER_ASSERT_NOW(a_trig_done, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]), "trigger and done in one beat")

  // digits stay decimal and the padding stays zero
  `UER_ASSERT_NOW(a_digits, m_axis_tvalid, m_axis_tdata[63:59] == 5'd0 && m_axis_tdata[18:15] <= 4'd9 && m_axis_tdata[22:19] <= 4'd9 && m_axis_tdata[26:23] <= 4'd9 && m_axis_tdata[30:27] <= 4'd9, "bad digit or padding")

endmodule

bind ultrasonic_echo_rangefinder uer_checker u_uer_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
